// File: design/bchd_pkg.sv
`timescale 1ns / 1ps
// Package for the button click and hold detector.
// Holds widths, register indexes, reset values, event codes and shared types.
// Depends on nothing.
package bchd_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int TIME_IN_W     = 32;
    localparam int MS_W          = 16;
    localparam int HELD_W        = 28;
    localparam int EV_W          = 3;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS     = 2'd2;

    localparam logic            ACTIVE_HIGH_RST = 1'b0;
    localparam logic [MS_W-1:0] DEBOUNCE_RST    = 16'd10;
    localparam logic [MS_W-1:0] HOLD_RST        = 16'd1000;

    localparam logic [EV_W-1:0] EV_NONE       = 3'd0;
    localparam logic [EV_W-1:0] EV_DOWN       = 3'd1;
    localparam logic [EV_W-1:0] EV_HOLD_START = 3'd2;
    localparam logic [EV_W-1:0] EV_CLICK      = 3'd3;
    localparam logic [EV_W-1:0] EV_HOLD_END   = 3'd4;

    localparam logic CMD_START = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE         = 4'd0,
        ST_INIT         = 4'd1,
        ST_WAIT_RELEASE = 4'd2,
        ST_UP           = 4'd3,
        ST_DOWN_DEB     = 4'd4,
        ST_DOWN         = 4'd5,
        ST_HOLD         = 4'd6,
        ST_HOLD_END_DEB = 4'd7,
        ST_UP_DEB       = 4'd8
    } mode_t;

    typedef struct packed {
        logic            active_high;
        logic [MS_W-1:0] debounce_ms;
        logic [MS_W-1:0] hold_ms;
    } cfg_t;

    typedef struct packed {
        logic                 cmd;
        logic                 level;
        logic [TIME_IN_W-1:0] time_ms;
        logic                 await_release;
    } item_t;

    typedef struct packed {
        logic [EV_W-1:0]   event_res;
        logic [HELD_W-1:0] held_ms;
    } res_t;

endpackage

// File: design/bchd_cfg.sv
`timescale 1ns / 1ps
// Configuration registers of the button detector.
// Depends on bchd_pkg.
module bchd_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bchd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bchd_pkg::MS_W-1:0]      cfg_data,
    output bchd_pkg::cfg_t                 cfg
);

    bchd_pkg::cfg_t cfg_reg;
    bchd_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                bchd_pkg::CFG_ACTIVE_HIGH: cfg_next.active_high = cfg_data[0];
                bchd_pkg::CFG_DEBOUNCE_MS: cfg_next.debounce_ms = cfg_data;
                bchd_pkg::CFG_HOLD_MS:     cfg_next.hold_ms     = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_high <= bchd_pkg::ACTIVE_HIGH_RST;
            cfg_reg.debounce_ms <= bchd_pkg::DEBOUNCE_RST;
            cfg_reg.hold_ms     <= bchd_pkg::HOLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: design/bchd_in_stage.sv
`timescale 1ns / 1ps
// Input register of the button detector with its valid bit.
// Depends on bchd_pkg.
module bchd_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  bchd_pkg::item_t in_item,
    input  logic            down_ready,
    output logic            s1_valid,
    output logic            s1_advance,
    output bchd_pkg::item_t s1_item
);

    logic            valid_reg;
    logic            valid_next;
    bchd_pkg::item_t item_reg;
    logic            accept;

    assign in_stall   = valid_reg && !down_ready;
    assign accept     = in_valid && !in_stall;
    assign s1_advance = valid_reg && down_ready;
    assign s1_valid   = valid_reg;
    assign s1_item    = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// File: design/bchd_core.sv
`timescale 1ns / 1ps
// Press, click and hold state machine with its press and release timestamps.
// Depends on bchd_pkg.
module bchd_core #(
    parameter int TIME_BITS = bchd_pkg::TIME_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  bchd_pkg::item_t item,
    input  bchd_pkg::cfg_t  cfg,
    output bchd_pkg::res_t  res
);

    bchd_pkg::mode_t      state_reg;
    bchd_pkg::mode_t      state_next;
    logic [TIME_BITS-1:0] press_time_reg;
    logic [TIME_BITS-1:0] press_time_next;
    logic [TIME_BITS-1:0] release_time_reg;
    logic [TIME_BITS-1:0] release_time_next;

    logic                 pressed;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] since_press;
    logic [TIME_BITS-1:0] since_release;
    logic [TIME_BITS-1:0] debounce_lim;
    logic [TIME_BITS-1:0] hold_lim;
    logic [bchd_pkg::EV_W-1:0] ev;

    assign pressed       = (item.level == cfg.active_high);
    assign now           = TIME_BITS'(item.time_ms);
    assign since_press   = now - press_time_reg;
    assign since_release = now - release_time_reg;
    assign debounce_lim  = TIME_BITS'(cfg.debounce_ms);
    assign hold_lim      = TIME_BITS'(cfg.hold_ms);

    always_comb
    begin
        state_next        = state_reg;
        press_time_next   = press_time_reg;
        release_time_next = release_time_reg;
        ev                = bchd_pkg::EV_NONE;
        if (item.cmd == bchd_pkg::CMD_START)
        begin
            press_time_next   = '0;
            release_time_next = '0;
            if (!pressed)
            begin
                state_next = bchd_pkg::ST_UP;
            end
            else if (item.await_release)
            begin
                state_next = bchd_pkg::ST_WAIT_RELEASE;
            end
            else
            begin
                state_next      = bchd_pkg::ST_DOWN_DEB;
                press_time_next = now;
            end
        end
        else
        begin
            unique case (state_reg)
                bchd_pkg::ST_WAIT_RELEASE:
                begin
                    if (!pressed)
                    begin
                        state_next = bchd_pkg::ST_UP;
                    end
                end
                bchd_pkg::ST_UP:
                begin
                    if (pressed)
                    begin
                        state_next      = bchd_pkg::ST_DOWN_DEB;
                        press_time_next = now;
                    end
                end
                bchd_pkg::ST_DOWN_DEB:
                begin
                    if (!pressed)
                    begin
                        state_next = bchd_pkg::ST_UP;
                    end
                    else if (since_press > debounce_lim)
                    begin
                        state_next = bchd_pkg::ST_DOWN;
                        ev         = bchd_pkg::EV_DOWN;
                    end
                end
                bchd_pkg::ST_DOWN:
                begin
                    if (!pressed)
                    begin
                        state_next        = bchd_pkg::ST_UP_DEB;
                        release_time_next = now;
                    end
                    else if (since_press > hold_lim)
                    begin
                        state_next = bchd_pkg::ST_HOLD;
                        ev         = bchd_pkg::EV_HOLD_START;
                    end
                end
                bchd_pkg::ST_UP_DEB:
                begin
                    if (pressed)
                    begin
                        state_next = bchd_pkg::ST_DOWN;
                    end
                    else if (since_release > debounce_lim)
                    begin
                        state_next = bchd_pkg::ST_UP;
                        ev         = bchd_pkg::EV_CLICK;
                    end
                end
                bchd_pkg::ST_HOLD:
                begin
                    if (!pressed)
                    begin
                        state_next        = bchd_pkg::ST_HOLD_END_DEB;
                        release_time_next = now;
                    end
                end
                bchd_pkg::ST_HOLD_END_DEB:
                begin
                    if (pressed)
                    begin
                        state_next = bchd_pkg::ST_HOLD;
                    end
                    else if (since_release > debounce_lim)
                    begin
                        state_next = bchd_pkg::ST_UP;
                        ev         = bchd_pkg::EV_HOLD_END;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end

        res.event_res = ev;
        if (ev != bchd_pkg::EV_NONE)
        begin
            res.held_ms = bchd_pkg::HELD_W'(since_press);
        end
        else
        begin
            res.held_ms = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bchd_pkg::ST_IDLE;
            press_time_reg   <= '0;
            release_time_reg <= '0;
        end
        else if (advance)
        begin
            state_reg        <= state_next;
            press_time_reg   <= press_time_next;
            release_time_reg <= release_time_next;
        end
    end

endmodule

// File: design/bchd_out_stage.sv
`timescale 1ns / 1ps
// Result register of the button detector with its valid bit.
// Depends on bchd_pkg.
module bchd_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  bchd_pkg::res_t up_res,
    output logic           out_valid,
    input  logic           out_stall,
    output bchd_pkg::res_t out_res
);

    logic           valid_reg;
    logic           valid_next;
    bchd_pkg::res_t res_reg;
    logic           load;

    assign up_ready  = !valid_reg || !out_stall;
    assign load      = up_valid && up_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= up_res;
        end
    end

endmodule

// File: design/button_click_hold_detector_unit.sv
`timescale 1ns / 1ps
// Button click and hold detector: one result item for every input item.
// The result item reaches the outputs through the input register and then the result register.
// Throughput is one item per cycle while out_stall is low; the state update is a single compare stage.
// Reset clears both valid bits, sets the detector idle with zero timestamps,
// and loads the default configuration (active low, 10 ms debounce, 1000 ms hold).
module button_click_hold_detector_unit #(
    parameter int TIME_BITS = bchd_pkg::TIME_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           cmd,
    input  logic                           level,
    input  logic [bchd_pkg::TIME_IN_W-1:0] time_ms,
    input  logic                           await_release,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bchd_pkg::EV_W-1:0]      event_res,
    output logic [bchd_pkg::HELD_W-1:0]    held_ms,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bchd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bchd_pkg::MS_W-1:0]      cfg_data
);

    bchd_pkg::cfg_t  cfg;
    bchd_pkg::item_t in_item;
    bchd_pkg::item_t s1_item;
    bchd_pkg::res_t  core_res;
    bchd_pkg::res_t  out_res;
    logic            s1_valid;
    logic            s1_advance;
    logic            down_ready;

    assign in_item.cmd           = cmd;
    assign in_item.level         = level;
    assign in_item.time_ms       = time_ms;
    assign in_item.await_release = await_release;
    assign event_res             = out_res.event_res;
    assign held_ms               = out_res.held_ms;

    bchd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bchd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .down_ready (down_ready),
        .s1_valid   (s1_valid),
        .s1_advance (s1_advance),
        .s1_item    (s1_item)
    );

    bchd_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_advance),
        .item    (s1_item),
        .cfg     (cfg),
        .res     (core_res)
    );

    bchd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (s1_valid),
        .up_ready  (down_ready),
        .up_res    (core_res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

endmodule

// File: design/bchd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the button detector and its bind to the top level.
// Depends on bchd_pkg and button_click_hold_detector_unit.
module bchd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [bchd_pkg::EV_W-1:0]      event_res,
    input logic [bchd_pkg::HELD_W-1:0]    held_ms
);

    // With no result item waiting, the detector must take a new item.
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with no result item pending");

    // A result item with no event carries no elapsed time.
    a_held_zero_on_none: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == bchd_pkg::EV_NONE) |-> held_ms == '0)
        else $error("held_ms nonzero on a result item with no event");

    // Only the defined event codes appear.
    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_res == bchd_pkg::EV_NONE || event_res == bchd_pkg::EV_DOWN
            || event_res == bchd_pkg::EV_HOLD_START || event_res == bchd_pkg::EV_CLICK
            || event_res == bchd_pkg::EV_HOLD_END))
        else $error("undefined event code on a result item");

    // A stalled result item stays in place.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(event_res) && $stable(held_ms)))
        else $error("stalled result item changed");

endmodule

bind button_click_hold_detector_unit bchd_checker u_bchd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .event_res (event_res),
    .held_ms   (held_ms)
);
